// ===== rtl/bat_pkg.sv =====
// shared types for the bump allocator and its block-table cells
package bat_pkg;

  // command codes carried in a request beat
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bat_cmd_t;

  // controls broadcast to every table cell
  typedef struct packed {
    logic start;  // load the search token at the head of the chain
    logic step;   // move the search token one cell down
    logic shift;  // close the gap left by a freed entry
    logic wr;     // write a new entry into the selected cell
  } bat_cell_ctl_t;

endpackage

// ===== rtl/bat_req_if.sv =====
// request channel: command beat into the allocator
interface bat_req_if #(
  parameter int SW = 9,
  parameter int OW = 8
);
  logic          valid;
  logic          ready;
  logic          command;
  logic [SW-1:0] alloc_size;
  logic [OW-1:0] free_offset;

  modport source (output valid, command, alloc_size, free_offset, input ready);
  modport sink   (input valid, command, alloc_size, free_offset, output ready);
endinterface

// ===== rtl/bat_rsp_if.sv =====
// response channel: result beat out of the allocator
interface bat_rsp_if #(
  parameter int SW = 9,
  parameter int OW = 8,
  parameter int CW = 5
);
  logic          valid;
  logic          ready;
  logic          ok;
  logic [OW-1:0] block_offset;
  logic [SW-1:0] freed_size;
  logic [CW-1:0] live_blocks;
  logic [SW-1:0] bytes_left;

  modport source (output valid, ok, block_offset, freed_size, live_blocks, bytes_left,
                  input ready);
  modport sink   (input valid, ok, block_offset, freed_size, live_blocks, bytes_left,
                  output ready);
endinterface

// ===== rtl/bat_cell.sv =====
// one block-table cell: holds one entry and a slot of the search token chain
module bat_cell #(
  parameter int SW = 9,
  parameter int OW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bat_pkg::bat_cell_ctl_t ctl,
  input  logic                  sel,
  input  logic                  live,
  input  logic [OW-1:0]         key,
  input  logic [SW-1:0]         wr_size,
  input  logic [OW-1:0]         wr_off,
  input  logic [SW-1:0]         nb_size,
  input  logic [OW-1:0]         nb_off,
  input  logic                  tok_in,
  output logic [SW-1:0]         size_o,
  output logic [OW-1:0]         off_o,
  output logic                  tok_o,
  output logic                  hit_o
);

  logic [SW-1:0] size_r;
  logic [OW-1:0] off_r;
  logic          tok_r;
  logic          past_r;

  // entry payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr && sel) begin
      size_r <= wr_size;
      off_r  <= wr_off;
    end else if (ctl.shift && !past_r) begin
      size_r <= nb_size;
      off_r  <= nb_off;
    end
  end

  // token marks the cell under test, past marks cells already tested
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      past_r <= 1'b0;
    end else if (ctl.start) begin
      tok_r  <= tok_in;
      past_r <= 1'b0;
    end else if (ctl.step) begin
      tok_r  <= tok_in;
      past_r <= past_r | tok_r;
    end
  end

  assign size_o = size_r;
  assign off_o  = off_r;
  assign tok_o  = tok_r;
  assign hit_o  = tok_r && live && (off_r == key);

endmodule

// ===== rtl/bump_allocator_with_block_table_core.sv =====
// top level of the bump allocator with its chain of block-table cells
//
// usage: requests enter on in_req (valid/ready), one beat per command, and
// each request yields exactly one response beat on out_rsp (valid/ready).
// an allocate hands out the current bump offset when the size fits, the
// table has room and the buffer is not exhausted; a free looks up the first
// live entry at the given offset, removes it and reports its size.
// an allocate passes from accept through the S_ALLOC state into the output
// register. a free loads the search token at the head of the cell chain and
// the token walks the chain one cell per cycle while the output register has
// room, until it hits the match or passes the live entries; removal closes
// the gap as the response is registered, every later cell copying its neighbor.
// one request is in flight at a time: the next request is taken no earlier
// than the edge where the previous response can first be taken. in_req.ready
// is high while idle, even while a finished response still sits in the
// output register.
// when out_rsp is stalled the block holds its work on the pending request
// and commits nothing until the output register has room.
// reset (rst_n low, synchronous) empties the table, restores the full
// buffer and drops any pending response; the cells need no clearing pass.
module bump_allocator_with_block_table_core #(
  parameter int BUFFER_BYTES  = 256,
  parameter int TABLE_ENTRIES = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  bat_req_if.sink   in_req,
  bat_rsp_if.source out_rsp
);

  localparam int SW = $clog2(BUFFER_BYTES + 1);   // size and byte count width
  localparam int OW = $clog2(BUFFER_BYTES);       // offset width
  localparam int CW = $clog2(TABLE_ENTRIES + 1);  // live count width
  localparam int N  = TABLE_ENTRIES;

  // controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ALLOC = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [SW-1:0] remain_r, remain_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] size_r;
  logic [OW-1:0] key_r;

  // output register
  logic          ovld_r, ovld_nxt;
  logic          ook_r, ook_nxt;
  logic [OW-1:0] ooff_r, ooff_nxt;
  logic [SW-1:0] ofree_r, ofree_nxt;
  logic [CW-1:0] olive_r, olive_nxt;
  logic [SW-1:0] oleft_r, oleft_nxt;

  // cell chain wiring
  bat_pkg::bat_cell_ctl_t ctl;
  logic [N-1:0]          sel, live, tok, hit, tok_in;
  logic [SW-1:0]         csize [N];
  logic [OW-1:0]         coff  [N];
  logic [SW-1:0]         nsize [N];
  logic [OW-1:0]         noff  [N];

  logic          accept;
  logic          adv;        // output register can take a beat this cycle
  logic          hit_any;
  logic          miss;
  logic [SW-1:0] hit_size;
  logic [OW-1:0] bump;
  logic          alloc_ok;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign adv          = !ovld_r || out_rsp.ready;

  // bump offset, meaningful only while bytes remain
  assign bump = OW'(SW'(BUFFER_BYTES) - remain_r);

  assign alloc_ok = (size_r <= remain_r) && (count_r < CW'(N)) && (remain_r != '0);

  // cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign sel[i]  = (count_r == CW'(i));
    assign live[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_head
      assign tok_in[i] = ctl.start;
    end else begin : g_link
      assign tok_in[i] = tok[i-1] && !ctl.start;
    end

    // last cell has no right neighbor; its value is beyond the live count
    if (i == N - 1) begin : g_tail
      assign nsize[i] = csize[i];
      assign noff[i]  = coff[i];
    end else begin : g_mid
      assign nsize[i] = csize[i+1];
      assign noff[i]  = coff[i+1];
    end

    bat_cell #(
      .SW (SW),
      .OW (OW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sel     (sel[i]),
      .live    (live[i]),
      .key     (key_r),
      .wr_size (size_r),
      .wr_off  (bump),
      .nb_size (nsize[i]),
      .nb_off  (noff[i]),
      .tok_in  (tok_in[i]),
      .size_o  (csize[i]),
      .off_o   (coff[i]),
      .tok_o   (tok[i]),
      .hit_o   (hit[i])
    );
  end

  // only one cell holds the token, so an or-reduce picks the hit entry size
  always_comb begin
    hit_size = '0;
    for (int i = 0; i < N; i++) begin
      if (hit[i]) begin
        hit_size = hit_size | csize[i];
      end
    end
  end

  assign hit_any = |hit;
  // token ran past the live entries or fell off the end of the chain
  assign miss    = !hit_any && ((tok == '0) || ((tok & ~live) != '0));

  // cell controls
  always_comb begin
    ctl.start = accept && (in_req.command == bat_pkg::CMD_FREE);
    ctl.step  = (state_r == S_SCAN) && adv && !hit_any && !miss;
    ctl.shift = (state_r == S_SCAN) && adv && hit_any;
    ctl.wr    = (state_r == S_ALLOC) && adv && alloc_ok;
  end

  // controller and response
  always_comb begin
    state_nxt  = state_r;
    remain_nxt = remain_r;
    count_nxt  = count_r;
    ovld_nxt   = ovld_r && !out_rsp.ready;
    ook_nxt    = ook_r;
    ooff_nxt   = ooff_r;
    ofree_nxt  = ofree_r;
    olive_nxt  = olive_r;
    oleft_nxt  = oleft_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_req.command == bat_pkg::CMD_FREE) ? S_SCAN : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (adv) begin
          if (alloc_ok) begin
            remain_nxt = remain_r - size_r;
            count_nxt  = count_r + CW'(1);
          end
          ovld_nxt  = 1'b1;
          ook_nxt   = alloc_ok;
          ooff_nxt  = alloc_ok ? bump : '0;
          ofree_nxt = '0;
          olive_nxt = alloc_ok ? count_r + CW'(1) : count_r;
          oleft_nxt = alloc_ok ? remain_r - size_r : remain_r;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (adv && (hit_any || miss)) begin
          if (hit_any) begin
            count_nxt = count_r - CW'(1);
          end
          ovld_nxt  = 1'b1;
          ook_nxt   = hit_any;
          ooff_nxt  = '0;
          ofree_nxt = hit_any ? hit_size : '0;
          olive_nxt = hit_any ? count_r - CW'(1) : count_r;
          oleft_nxt = remain_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      remain_r <= SW'(BUFFER_BYTES);
      count_r  <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      remain_r <= remain_nxt;
      count_r  <= count_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  // request and response payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      size_r <= in_req.alloc_size;
      key_r  <= in_req.free_offset;
    end
    ook_r   <= ook_nxt;
    ooff_r  <= ooff_nxt;
    ofree_r <= ofree_nxt;
    olive_r <= olive_nxt;
    oleft_r <= oleft_nxt;
  end

  assign out_rsp.valid        = ovld_r;
  assign out_rsp.ok           = ook_r;
  assign out_rsp.block_offset = ooff_r;
  assign out_rsp.freed_size   = ofree_r;
  assign out_rsp.live_blocks  = olive_r;
  assign out_rsp.bytes_left   = oleft_r;

endmodule

// ===== tb/alloc_check_pkg.sv =====
// predictor and result checker for the bump allocator testbench
package alloc_check_pkg;

  localparam int BUF_BYTES   = 256;
  localparam int TBL_ENTRIES = 16;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } alloc_cmd_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] block_offset;
    logic [8:0] freed_size;
    logic [4:0] live_blocks;
    logic [8:0] bytes_left;
  } alloc_result_t;

  class alloc_result_checker;
    int unsigned   bytes_free;
    int unsigned   live_cnt;
    logic [8:0]    blk_size [TBL_ENTRIES];
    logic [7:0]    blk_off  [TBL_ENTRIES];
    alloc_result_t awaiting_results [$];
    int unsigned   fail_count;

    function new();
      bytes_free = BUF_BYTES;
      live_cnt   = 0;
      fail_count = 0;
    endfunction

    // advance the allocator state by one accepted request, queue its result
    function void note_request(alloc_cmd_t cmd, logic [8:0] size, logic [7:0] off);
      alloc_result_t res;
      int unsigned   bump;
      int            hit;
      res = '0;
      hit = -1;
      if (cmd == CMD_ALLOC) begin
        bump = BUF_BYTES - bytes_free;
        if (size <= bytes_free && live_cnt < TBL_ENTRIES && bump < BUF_BYTES) begin
          blk_size[live_cnt] = size;
          blk_off[live_cnt]  = 8'(bump);
          live_cnt++;
          bytes_free -= size;
          res.ok = 1'b1;
          res.block_offset = 8'(bump);
        end
      end else begin
        for (int i = 0; i < live_cnt; i++)
          if (hit < 0 && blk_off[i] == off) hit = i;
        if (hit >= 0) begin
          res.ok = 1'b1;
          res.freed_size = blk_size[hit];
          for (int j = hit; j + 1 < live_cnt; j++) begin
            blk_size[j] = blk_size[j + 1];
            blk_off[j]  = blk_off[j + 1];
          end
          live_cnt--;
        end
      end
      res.live_blocks = 5'(live_cnt);
      res.bytes_left  = 9'(bytes_free);
      awaiting_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [8:0] want, logic [8:0] got,
                                longint unsigned stamp);
      if (got !== want) begin
        $display("%0d ns: %s expected %0d, actual %0d", stamp, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(alloc_result_t got, longint unsigned stamp);
      alloc_result_t want;
      if (awaiting_results.size() == 0) begin
        $display("%0d ns: unexpected result beat, expected none, actual %p", stamp, got);
        fail_count++;
        return;
      end
      want = awaiting_results.pop_front();
      compare_field("ok", 9'(want.ok), 9'(got.ok), stamp);
      compare_field("block_offset", 9'(want.block_offset), 9'(got.block_offset), stamp);
      compare_field("freed_size", want.freed_size, got.freed_size, stamp);
      compare_field("live_blocks", 9'(want.live_blocks), 9'(got.live_blocks), stamp);
      compare_field("bytes_left", want.bytes_left, got.bytes_left, stamp);
    endfunction

    // results still owed count as failures
    function int unsigned close_out();
      foreach (awaiting_results[i])
        $display("missing result beat, expected %p, actual none", awaiting_results[i]);
      fail_count += awaiting_results.size();
      return fail_count;
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// top-level testbench for the bump allocator with block table
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // generous cap: one request in flight, so even heavy stalls stay far below this
  localparam int CYCLE_LIMIT = 400_000;

  logic clk = 1'b0;
  logic rst_n;

  // idling odds in percent, changed between phases
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  alloc_check_pkg::alloc_result_checker tbl_model = new();

  bat_req_if #(.SW(9), .OW(8))           req_ch ();
  bat_rsp_if #(.SW(9), .OW(8), .CW(5))   rsp_ch ();

  bump_allocator_with_block_table_core #(
    .BUFFER_BYTES  (alloc_check_pkg::BUF_BYTES),
    .TABLE_ENTRIES (alloc_check_pkg::TBL_ENTRIES)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // result side: sample the beat at the edge, then pick ready for the next cycle
  initial begin
    alloc_check_pkg::alloc_result_t seen;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        seen.ok           = rsp_ch.ok;
        seen.block_offset = rsp_ch.block_offset;
        seen.freed_size   = rsp_ch.freed_size;
        seen.live_blocks  = rsp_ch.live_blocks;
        seen.bytes_left   = rsp_ch.bytes_left;
        tbl_model.check_result(seen, $time);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one request beat; an optional idle gap first, then hold valid until accepted.
  // valid is left high on return so back-to-back beats never drop it
  task automatic send_beat(input alloc_check_pkg::alloc_cmd_t cmd, input logic [8:0] size,
                           input logic [7:0] off);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.alloc_size  <= size;
    req_ch.free_offset <= off;
    do @(posedge clk); while (!req_ch.ready);
    tbl_model.note_request(cmd, size, off);
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (tbl_model.awaiting_results.size() != 0);
  endtask

  // corner cases: empty table, duplicate zero-size offsets, oversize, table full
  task automatic directed_checks();
    send_beat(alloc_check_pkg::CMD_FREE, 9'd0, 8'd0);      // free on an empty table misses
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd0, 8'd0);     // zero-size block at offset 0
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd0, 8'd0);     // second zero-size block, same offset
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd3, 8'd0);     // real block also at offset 0
    send_beat(alloc_check_pkg::CMD_FREE, 9'd0, 8'd0);      // only the first match goes
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd256, 8'd255); // largest size no longer fits
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd254, 8'd0);   // one byte too many
    send_beat(alloc_check_pkg::CMD_FREE, 9'd256, 8'd255);  // unknown offset
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd1, 8'd0);
    send_beat(alloc_check_pkg::CMD_FREE, 9'd0, 8'd3);
    // fill the table with zero-size blocks, last one is refused
    repeat (alloc_check_pkg::TBL_ENTRIES - tbl_model.live_cnt + 1)
      send_beat(alloc_check_pkg::CMD_ALLOC, 9'd0, 8'd0);
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd1, 8'd0);     // full table beats a fitting size
  endtask

  // random mix: frees mostly aim at live blocks, allocs mostly zero-size so the
  // buffer lasts the whole run; a few small real blocks and oversize requests
  task automatic random_traffic(input int unsigned count);
    int unsigned pick;
    int unsigned free_pct;
    logic [8:0]  size;
    repeat (count) begin
      free_pct = (tbl_model.live_cnt > 10) ? 60 : 35;
      pick = $urandom_range(99);
      if (pick < free_pct) begin
        if (tbl_model.live_cnt != 0 && $urandom_range(99) < 85)
          send_beat(alloc_check_pkg::CMD_FREE, 9'($urandom_range(256)),
                    tbl_model.blk_off[$urandom_range(tbl_model.live_cnt - 1)]);
        else
          send_beat(alloc_check_pkg::CMD_FREE, 9'($urandom_range(256)),
                    8'($urandom_range(255)));
      end else begin
        if (pick < 80)
          size = '0;
        else if (pick < 90)
          // keep a few bytes back for the exhaustion check at the end
          size = (tbl_model.bytes_free > 8) ? 9'($urandom_range(2, 1)) : '0;
        else if (tbl_model.bytes_free < alloc_check_pkg::BUF_BYTES)
          size = 9'($urandom_range(alloc_check_pkg::BUF_BYTES, tbl_model.bytes_free + 1));
        else
          size = 9'(alloc_check_pkg::BUF_BYTES);
        send_beat(alloc_check_pkg::CMD_ALLOC, size, 8'($urandom_range(255)));
      end
    end
  endtask

  // use up the buffer, show that even zero-size allocs then fail, empty the table
  task automatic exhaust_buffer();
    if (tbl_model.live_cnt == alloc_check_pkg::TBL_ENTRIES)
      send_beat(alloc_check_pkg::CMD_FREE, 9'd0, tbl_model.blk_off[0]);
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'(tbl_model.bytes_free), 8'd0);
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd0, 8'd0);
    send_beat(alloc_check_pkg::CMD_ALLOC, 9'd1, 8'd0);
    while (tbl_model.live_cnt != 0)
      send_beat(alloc_check_pkg::CMD_FREE, 9'd0, tbl_model.blk_off[tbl_model.live_cnt - 1]);
    send_beat(alloc_check_pkg::CMD_FREE, 9'd0, 8'd0);
  endtask

  initial begin
    req_ch.valid       <= 1'b0;
    req_ch.command     <= alloc_check_pkg::CMD_ALLOC;
    req_ch.alloc_size  <= '0;
    req_ch.free_offset <= '0;
    rst_n              <= 1'b0;
    send_idle_pct  = 6;
    recv_stall_pct = 70;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: sender mostly busy, receiver stalls a lot
    directed_checks();
    wait_for_drain();
    random_traffic(200);
    wait_for_drain();
    random_traffic(200);
    wait_for_drain();

    // phase two: the other way round
    send_idle_pct  = 70;
    recv_stall_pct = 6;
    random_traffic(390);
    wait_for_drain();

    // phase three: full rate both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(360);
    exhaust_buffer();

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (tbl_model.awaiting_results.size() != 0);
    // longest free walks the whole table, leave room for a stray beat
    repeat (alloc_check_pkg::TBL_ENTRIES + 4) @(posedge clk);
    if (tbl_model.close_out() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
